// ----- rtl/nia_pkg.sv -----
`default_nettype none

package nia_pkg;

    localparam int PORT_DIMS      = 4;
    localparam int IDX_W          = 8;
    localparam int OPC_W          = 2;
    localparam int OFF_W          = 32;
    localparam int SIZE_W         = 9;
    localparam int NDIM_W         = 3;
    localparam int CNT_W          = 2;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int S_TDATA_W      = PORT_DIMS * IDX_W;
    localparam int M_TDATA_W      = OFF_W + PORT_DIMS * IDX_W;
    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_INDEX_BITS = 8;

    typedef enum logic [OPC_W-1:0] {
        OP_LOOKUP  = 2'd0,
        OP_STEP    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    localparam logic [NDIM_W-1:0] REG_NUM_DIMS  = 3'd0;
    localparam logic [NDIM_W-1:0] REG_SIZE_DIM0 = 3'd1;
    localparam logic [NDIM_W-1:0] REG_SIZE_DIM1 = 3'd2;
    localparam logic [NDIM_W-1:0] REG_SIZE_DIM2 = 3'd3;
    localparam logic [NDIM_W-1:0] REG_SIZE_DIM3 = 3'd4;

    typedef logic [PORT_DIMS-1:0][SIZE_W-1:0] t_extents;

    typedef struct packed {
        logic             load;
        logic             sel_iter;
        logic             clr_iter;
        logic             acc_clr;
        logic             acc_step;
        logic [CNT_W-1:0] lane;
        logic             out_load;
        logic             iter_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/nia_cfg.sv -----
`default_nettype none

module nia_cfg #(
    parameter int MAX_DIMS   = nia_pkg::DEF_MAX_DIMS,
    parameter int INDEX_BITS = nia_pkg::DEF_INDEX_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nia_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [nia_pkg::DATA_W-1:0]    pwdata,
    output logic      [nia_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic      [nia_pkg::NDIM_W-1:0]    o_active_dims,
    output nia_pkg::t_extents                  o_extents
);

    localparam int LIM = (MAX_DIMS < nia_pkg::PORT_DIMS) ? MAX_DIMS : nia_pkg::PORT_DIMS;
    localparam int CAP = 1 << INDEX_BITS;

    logic [nia_pkg::NDIM_W-1:0]                           r_num_dims;
    logic [nia_pkg::PORT_DIMS-1:0][nia_pkg::SIZE_W-1:0]   r_size;
    logic [nia_pkg::NDIM_W-1:0]                           w_index;
    logic                                                 w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[nia_pkg::ADDR_W-1:2];
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= nia_pkg::NDIM_W'(1);
            for (int d = 0; d < nia_pkg::PORT_DIMS; d++) begin
                r_size[d] <= nia_pkg::SIZE_W'(1);
            end
        end else if (w_write) begin
            case (w_index)
                nia_pkg::REG_NUM_DIMS:  r_num_dims <= pwdata[nia_pkg::NDIM_W-1:0];
                nia_pkg::REG_SIZE_DIM0: r_size[0]  <= pwdata[nia_pkg::SIZE_W-1:0];
                nia_pkg::REG_SIZE_DIM1: r_size[1]  <= pwdata[nia_pkg::SIZE_W-1:0];
                nia_pkg::REG_SIZE_DIM2: r_size[2]  <= pwdata[nia_pkg::SIZE_W-1:0];
                nia_pkg::REG_SIZE_DIM3: r_size[3]  <= pwdata[nia_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            nia_pkg::REG_NUM_DIMS:  prdata = nia_pkg::DATA_W'(r_num_dims);
            nia_pkg::REG_SIZE_DIM0: prdata = nia_pkg::DATA_W'(r_size[0]);
            nia_pkg::REG_SIZE_DIM1: prdata = nia_pkg::DATA_W'(r_size[1]);
            nia_pkg::REG_SIZE_DIM2: prdata = nia_pkg::DATA_W'(r_size[2]);
            nia_pkg::REG_SIZE_DIM3: prdata = nia_pkg::DATA_W'(r_size[3]);
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        if (r_num_dims > nia_pkg::NDIM_W'(LIM)) begin
            o_active_dims = nia_pkg::NDIM_W'(LIM);
        end else begin
            o_active_dims = r_num_dims;
        end
    end

    always_comb begin
        for (int d = 0; d < nia_pkg::PORT_DIMS; d++) begin
            if (int'(r_size[d]) > CAP) begin
                o_extents[d] = nia_pkg::SIZE_W'(CAP);
            end else begin
                o_extents[d] = r_size[d];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nia_ctrl.sv -----
`default_nettype none

module nia_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic [nia_pkg::OPC_W-1:0]     i_opcode,
    input  wire logic [nia_pkg::NDIM_W-1:0]    i_active_dims,
    input  wire nia_pkg::t_dp_stat             i_stat,
    output logic                               o_s_tready,
    output nia_pkg::t_dp_cmd                   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [nia_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_step, n_step;
    logic                        w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.lane     = r_cnt;
        o_cmd.sel_iter = (i_opcode == nia_pkg::OP_STEP);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        nia_pkg::OP_LOOKUP, nia_pkg::OP_STEP: begin
                            o_cmd.acc_clr = 1'b1;
                            n_step        = (i_opcode == nia_pkg::OP_STEP);
                            n_cnt         = '0;
                            n_state       = (i_active_dims == '0) ? S_FIN : S_CALC;
                        end
                        nia_pkg::OP_RESTART: o_cmd.clr_iter = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CALC: begin
                o_cmd.acc_step = 1'b1;
                if ((nia_pkg::NDIM_W'(r_cnt) + nia_pkg::NDIM_W'(1)) == i_active_dims) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + nia_pkg::CNT_W'(1);
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.iter_adv = r_step;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nia_dp.sv -----
`default_nettype none

module nia_dp #(
    parameter int MAX_DIMS   = nia_pkg::DEF_MAX_DIMS,
    parameter int INDEX_BITS = nia_pkg::DEF_INDEX_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire nia_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [nia_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  wire logic [nia_pkg::NDIM_W-1:0]       i_active_dims,
    input  wire nia_pkg::t_extents                i_extents,
    input  wire logic                             i_m_tready,
    output nia_pkg::t_dp_stat                     o_stat,
    output logic                                  o_m_tvalid,
    output logic      [nia_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int ITER_LANES = (MAX_DIMS < nia_pkg::PORT_DIMS) ? MAX_DIMS : nia_pkg::PORT_DIMS;
    localparam int CMP_W      = (INDEX_BITS + 1 > nia_pkg::SIZE_W) ? INDEX_BITS + 1
                                                                   : nia_pkg::SIZE_W;

    logic [nia_pkg::PORT_DIMS-1:0][INDEX_BITS-1:0]   r_tup;
    logic [nia_pkg::PORT_DIMS-1:0][INDEX_BITS-1:0]   w_load;
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0]             r_iter, n_iter;
    logic [nia_pkg::OFF_W-1:0]                       r_acc;
    logic [nia_pkg::OFF_W-1:0]                       w_prod;
    logic [nia_pkg::PORT_DIMS*nia_pkg::IDX_W-1:0]    w_out_idx;
    logic                                            w_wrap;
    logic                                            r_valid;
    logic [nia_pkg::M_TDATA_W-1:0]                   r_data;
    logic                                            r_last;

    for (genvar d = 0; d < nia_pkg::PORT_DIMS; d++) begin : g_lane
        logic [INDEX_BITS+nia_pkg::IDX_W-1:0] w_in_ext;
        logic [INDEX_BITS+nia_pkg::IDX_W-1:0] w_tup_ext;
        logic [INDEX_BITS-1:0]                w_iter_val;

        assign w_in_ext  = {{INDEX_BITS{1'b0}}, i_s_tdata[d*nia_pkg::IDX_W +: nia_pkg::IDX_W]};
        assign w_tup_ext = {{nia_pkg::IDX_W{1'b0}}, r_tup[d]};
        if (d < MAX_DIMS) begin : g_iter
            assign w_iter_val = r_iter[d];
        end else begin : g_none
            assign w_iter_val = '0;
        end
        assign w_load[d] = i_cmd.sel_iter ? w_iter_val : w_in_ext[INDEX_BITS-1:0];
        assign w_out_idx[d*nia_pkg::IDX_W +: nia_pkg::IDX_W] = w_tup_ext[nia_pkg::IDX_W-1:0];
    end

    assign w_prod = r_acc * nia_pkg::OFF_W'(i_extents[i_cmd.lane]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tup <= w_load;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_step) begin
            r_acc <= w_prod + nia_pkg::OFF_W'(r_tup[i_cmd.lane]);
        end
    end

    always_comb begin
        logic                 carry;
        logic [CMP_W-1:0]     v;
        n_iter = r_iter;
        carry  = 1'b1;
        v      = '0;
        for (int i = ITER_LANES - 1; i >= 0; i--) begin
            if ((i < int'(i_active_dims)) && carry) begin
                v = CMP_W'(r_iter[i]) + CMP_W'(1);
                if (v < CMP_W'(i_extents[i])) begin
                    n_iter[i] = v[INDEX_BITS-1:0];
                    carry     = 1'b0;
                end else begin
                    n_iter[i] = '0;
                end
            end
        end
        w_wrap = carry;
        if (i_cmd.clr_iter) begin
            n_iter = '0;
        end else if (!i_cmd.iter_adv) begin
            n_iter = r_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else begin
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_data <= {w_out_idx, r_acc};
            r_last <= i_cmd.iter_adv && w_wrap;
        end
    end

    assign o_stat.out_free = !r_valid || i_m_tready;
    assign o_m_tvalid      = r_valid;
    assign o_m_tdata       = r_data;
    assign o_m_tlast       = r_last;

endmodule

`default_nettype wire

// ----- rtl/nd_index_address_generator.sv -----
// Row-major address generator for up to four dimensions.
// Slave stream: tuser carries the opcode (lookup, step, restart, ignored);
// tdata carries idx0..idx3, one byte each, idx0 lowest.
// Master stream: tdata carries flat_offset in bits 31:0 and out_idx0..out_idx3
// above it; tlast is set on a step that wrapped the iterator to all zeros.
// The APB port holds num_dims and the four extents at byte addresses 0 to 16;
// the user is to write it only while the block is idle; the block does not enforce this.
// A lookup or step word goes through the CALC state, which is skipped when no
// dimension is in use; there the offset is built by one multiply-add per
// dimension in a single shared unit. The word then waits in the FIN state
// until its result moves into the output register; only then is the next
// word taken. A restart or an ignored opcode yields no result.
// One word is in work at a time; a new word is taken as soon as the previous
// one has moved into the output register, even while that result waits.
// When the receiver stalls, the result holds in the output register and the
// block waits before loading the next one.
// Reset sets one dimension of extent one and clears the iterator.
`default_nettype none

module nd_index_address_generator #(
    parameter int MAX_DIMS   = nia_pkg::DEF_MAX_DIMS,
    parameter int INDEX_BITS = nia_pkg::DEF_INDEX_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // idx0, idx1, idx2, idx3
    input  wire logic [nia_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // opcode
    input  wire logic [nia_pkg::OPC_W-1:0]        i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // flat_offset, out_idx0, out_idx1, out_idx2, out_idx3
    output logic      [nia_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                                  o_m_tlast,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [nia_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [nia_pkg::DATA_W-1:0]       pwdata,
    output logic      [nia_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready
);

    logic [nia_pkg::NDIM_W-1:0]  w_active_dims;
    nia_pkg::t_extents           w_extents;
    nia_pkg::t_dp_cmd            w_cmd;
    nia_pkg::t_dp_stat           w_stat;

    nia_cfg #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_active_dims (w_active_dims),
        .o_extents     (w_extents)
    );

    nia_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_opcode      (i_s_tuser),
        .i_active_dims (w_active_dims),
        .i_stat        (w_stat),
        .o_s_tready    (o_s_tready),
        .o_cmd         (w_cmd)
    );

    nia_dp #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_s_tdata     (i_s_tdata),
        .i_active_dims (w_active_dims),
        .i_extents     (w_extents),
        .i_m_tready    (i_m_tready),
        .o_stat        (w_stat),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/nia_chk.sv -----
`default_nettype none

module nia_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic [nia_pkg::OPC_W-1:0]        i_s_tuser,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [nia_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input wire logic                             o_m_tlast
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready
        && (i_s_tuser == nia_pkg::OP_LOOKUP || i_s_tuser == nia_pkg::OP_STEP)
        |=> !o_s_tready)
        else $error("input taken while a word is in work");

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared without a word in work");

endmodule

bind nd_index_address_generator nia_chk u_nia_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
